/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared same-cycle and next-cycle implication checks for the rtl core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LCGE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcge assertion failed");

// next-cycle implication
`define LCGE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcge assertion failed");

`endif

/* rtl/core/lcge_pkg.sv */
// ----------------------------------------------------------------------------
// lcge_pkg
// shared types and constants of the life cell generation engine
// ----------------------------------------------------------------------------
package lcge_pkg;

   localparam int COORD_W    = 6;
   localparam int CMD_W      = 2;
   localparam int THR_W      = 6;
   localparam int COUNT_W    = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam logic [THR_W-1:0]   THR_RESET   = 6'd10;
   localparam logic [COUNT_W-1:0] BIRTH_COUNT = 4'd3;
   localparam logic [COUNT_W-1:0] KEEP_COUNT  = 4'd2;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd2;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } store_ctl_type;

   typedef struct packed {
      logic clear;
      logic hit_a;
      logic hit_b;
      logic hit_age;
   } fwd_type;

   typedef struct packed {
      logic alive_next;
      logic born;
      logic died;
      logic aged;
   } cell_flags_type;

   typedef struct packed {
      logic               aged;
      logic               died;
      logic               born;
      logic               alive_next;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] pos_x;
   } rsp_word_type;

endpackage

/* rtl/core/lcge_store.sv */
// ----------------------------------------------------------------------------
// lcge_store
// cell state and age memories with per-column valid bits for a clear without a clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcge_store import lcge_pkg::*; #(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64,
   parameter int AGE_BITS    = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   input  store_ctl_type                  ctl,
   input  logic [$clog2(GRID_WIDTH)-1:0]  rd_col_a,
   input  logic [$clog2(GRID_WIDTH)-1:0]  rd_col_b,
   input  logic [$clog2(GRID_HEIGHT)-1:0] rd_row,
   input  logic [$clog2(GRID_WIDTH)-1:0]  wr_col,
   input  logic [$clog2(GRID_HEIGHT)-1:0] wr_row,
   input  logic                           wr_alive,
   input  logic [AGE_BITS-1:0]            wr_age,
   output logic [GRID_HEIGHT-1:0]         rd_word_a,
   output logic [GRID_HEIGHT-1:0]         rd_word_b,
   output logic                           rd_valid_a,
   output logic                           rd_valid_b,
   output logic [AGE_BITS-1:0]            rd_age
);

   localparam int COL_W = $clog2(GRID_WIDTH);
   localparam int ROW_W = $clog2(GRID_HEIGHT);
   localparam int AGE_DEPTH = 2 ** (COL_W + ROW_W);

   logic [GRID_HEIGHT-1:0] alive_mem [GRID_WIDTH];
   logic [AGE_BITS-1:0]    age_mem [AGE_DEPTH];
   logic [GRID_WIDTH-1:0]  valid_ff;
   logic [GRID_HEIGHT-1:0] wr_onehot;

   assign wr_onehot = GRID_HEIGHT'(1) << wr_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_col] <= 1'b1;
      end
   end

   // first write into a stale column rewrites the whole word
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         if (valid_ff[wr_col]) begin
            alive_mem[wr_col][wr_row] <= wr_alive;
         end else begin
            alive_mem[wr_col] <= wr_onehot & {GRID_HEIGHT{wr_alive}};
         end
         age_mem[{wr_col, wr_row}] <= wr_age;
      end
      if (ctl.rd_en) begin
         rd_word_a  <= alive_mem[rd_col_a];
         rd_word_b  <= alive_mem[rd_col_b];
         rd_valid_a <= valid_ff[rd_col_a];
         rd_valid_b <= valid_ff[rd_col_b];
         rd_age     <= age_mem[{rd_col_a, rd_row}];
      end
   end

   `LCGE_ASSERT_NEXT(a_clear_drops_valid, clock, reset, ctl.clear, valid_ff == '0)

endmodule

/* rtl/core/lcge_rule.sv */
// ----------------------------------------------------------------------------
// lcge_rule
// neighbor count, life rule and age update for one cell
// ----------------------------------------------------------------------------
module lcge_rule import lcge_pkg::*; #(
   parameter int GRID_HEIGHT = 64,
   parameter int AGE_BITS    = 6
) (
   input  logic [GRID_HEIGHT-1:0]         hold0,
   input  logic [GRID_HEIGHT-1:0]         hold1,
   input  logic [GRID_HEIGHT-1:0]         ahead,
   input  logic [$clog2(GRID_HEIGHT)-1:0] row,
   input  logic [AGE_BITS-1:0]            age_old,
   input  logic [THR_W-1:0]               thr,
   output cell_flags_type                 flags,
   output logic [AGE_BITS-1:0]            age_new
);

   localparam int PAD_IW = $clog2(GRID_HEIGHT + 2);
   localparam int CMP_W  = ((AGE_BITS > THR_W) ? AGE_BITS : THR_W) + 1;
   localparam logic [CMP_W-1:0] AGE_MAX = CMP_W'((1 << AGE_BITS) - 1);

   logic [GRID_HEIGHT+1:0] pad0, pad1, pad2;
   logic [PAD_IW-1:0]      row_ext;
   logic [2:0]             win0, win1, win2;
   logic [COUNT_W-1:0]     count;
   logic                   old;
   logic                   next;
   logic [CMP_W-1:0]       thr_c, cap, inc, age_sel;

   // dead rows above and below the grid
   assign pad0    = {1'b0, hold0, 1'b0};
   assign pad1    = {1'b0, hold1, 1'b0};
   assign pad2    = {1'b0, ahead, 1'b0};
   assign row_ext = PAD_IW'(row);
   assign win0    = pad0[row_ext +: 3];
   assign win1    = pad1[row_ext +: 3];
   assign win2    = pad2[row_ext +: 3];

   assign count = COUNT_W'(win0[0]) + COUNT_W'(win0[1]) + COUNT_W'(win0[2])
                + COUNT_W'(win1[0]) + COUNT_W'(win1[2])
                + COUNT_W'(win2[0]) + COUNT_W'(win2[1]) + COUNT_W'(win2[2]);

   assign old  = hold1[row];
   assign next = old ? (count == KEEP_COUNT || count == BIRTH_COUNT)
                     : (count == BIRTH_COUNT);

   assign thr_c   = CMP_W'(thr);
   assign cap     = (thr_c < AGE_MAX) ? thr_c : AGE_MAX;
   assign inc     = CMP_W'(age_old) + CMP_W'(1);
   assign age_sel = (next && old) ? ((inc > cap) ? cap : inc) : '0;
   assign age_new = AGE_BITS'(age_sel);

   assign flags.alive_next = next;
   assign flags.born       = next && !old;
   assign flags.died       = !next && old;
   assign flags.aged       = next && (age_sel >= thr_c);

endmodule

/* rtl/core/life_cell_generation_engine_top.sv */
// Life cell generation engine: a Conway Life grid of GRID_WIDTH x GRID_HEIGHT
// cells, dead beyond the edges, each living cell carrying a saturating age.
// Each request word is a clear, a set-alive or one evaluation step of the
// column-major generation scan; only evaluations return a response word.
// One request is taken every cycle while no evaluation waits on a stalled
// response, and a response comes from the registered read of the cell
// memories followed by the single rule stage and the response register.
// Clear takes effect through a valid bit per column, so there is no clearing
// pass after reset or clear.
// ----------------------------------------------------------------------------
// life_cell_generation_engine_top
// request decode, scan control, neighborhood hold columns and response stage
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module life_cell_generation_engine_top import lcge_pkg::*; #(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64,
   parameter int AGE_BITS    = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // cell_x, cell_y, zero fill
   input  logic [CMD_W-1:0]      req_tuser,  // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // pos_x, pos_y, alive_next, born, died, aged
   output logic                  rsp_tlast,  // gen_last
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [THR_W-1:0]      csr_wdata   // age_threshold
);

   localparam int COL_W = $clog2(GRID_WIDTH);
   localparam int ROW_W = $clog2(GRID_HEIGHT);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_WIDTH - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_HEIGHT - 1);

   logic [THR_W-1:0]       thr_ff;
   logic [COL_W-1:0]       scan_x_ff, scan_x_in;
   logic [ROW_W-1:0]       scan_y_ff, scan_y_in;
   logic                   s1_vld_ff;
   logic [CMD_W-1:0]       s1_cmd_ff;
   logic [COORD_W-1:0]     s1_cx_ff, s1_cy_ff;
   logic [COL_W-1:0]       s1_x_ff;
   logic [ROW_W-1:0]       s1_y_ff;
   logic                   s1_edge_ff;
   fwd_type                s1_fwd_ff, fwd_in;
   logic [ROW_W-1:0]       s1_fwd_row_ff;
   logic [GRID_HEIGHT-1:0] hold0_ff, hold1_ff, hold0_in, hold1_in;
   logic                   rsp_vld_ff;
   rsp_word_type           rsp_word_ff;
   logic                   rsp_last_ff;

   logic [COORD_W-1:0]     req_cx, req_cy;
   logic [CMD_W-1:0]       req_cmd;
   logic                   req_fire;
   logic                   s1_is_eval, s1_move;
   logic                   set_ok;
   logic [COL_W-1:0]       set_col, rd_col_b;
   logic [ROW_W-1:0]       set_row;
   store_ctl_type          store_ctl;
   logic [COL_W-1:0]       wr_col;
   logic [ROW_W-1:0]       wr_row;
   logic                   wr_alive;
   logic [AGE_BITS-1:0]    wr_age;
   logic [GRID_HEIGHT-1:0] rd_word_a, rd_word_b, col_a_eff, col_b_eff, fwd_onehot;
   logic                   rd_valid_a, rd_valid_b;
   logic [AGE_BITS-1:0]    rd_age, age_eff, age_new;
   cell_flags_type         flags;
   logic                   s1_last;
   logic                   rsp_flags_ok, rsp_at_corner;

   assign req_cmd = req_tuser;
   assign req_cx  = req_tdata[COORD_W-1:0];
   assign req_cy  = req_tdata[2*COORD_W-1:COORD_W];

   assign s1_is_eval = (s1_cmd_ff == CMD_EVAL);
   assign s1_move    = s1_vld_ff && (!s1_is_eval || !rsp_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || s1_move;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign set_ok  = (32'(s1_cx_ff) < 32'(GRID_WIDTH)) && (32'(s1_cy_ff) < 32'(GRID_HEIGHT));
   assign set_col = COL_W'(s1_cx_ff);
   assign set_row = ROW_W'(s1_cy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_wdata;
      end
   end

   // scan position moves at accept so reads line up with the rule stage
   always_comb begin
      scan_x_in = scan_x_ff;
      scan_y_in = scan_y_ff;
      if (req_fire) begin
         unique case (req_cmd)
            CMD_CLEAR: begin
               scan_x_in = '0;
               scan_y_in = '0;
            end
            CMD_EVAL: begin
               if (scan_y_ff == ROW_LAST) begin
                  scan_y_in = '0;
                  scan_x_in = (scan_x_ff == COL_LAST) ? '0 : scan_x_ff + COL_W'(1);
               end else begin
                  scan_y_in = scan_y_ff + ROW_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rd_col_b = (scan_x_ff == COL_LAST) ? '0 : scan_x_ff + COL_W'(1);

   // the word leaving the rule stage writes on the same edge as this read
   always_comb begin
      fwd_in.clear   = s1_vld_ff && (s1_cmd_ff == CMD_CLEAR);
      fwd_in.hit_a   = s1_vld_ff && (s1_cmd_ff == CMD_SET) && set_ok && (set_col == scan_x_ff);
      fwd_in.hit_b   = s1_vld_ff && (s1_cmd_ff == CMD_SET) && set_ok && (set_col == rd_col_b);
      fwd_in.hit_age = fwd_in.hit_a && (set_row == scan_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_x_ff <= '0;
         scan_y_ff <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         scan_x_ff <= scan_x_in;
         scan_y_ff <= scan_y_in;
         if (req_fire) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_move) begin
            s1_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff     <= req_cmd;
         s1_cx_ff      <= req_cx;
         s1_cy_ff      <= req_cy;
         s1_x_ff       <= scan_x_ff;
         s1_y_ff       <= scan_y_ff;
         s1_edge_ff    <= (scan_x_ff == COL_LAST);
         s1_fwd_ff     <= fwd_in;
         s1_fwd_row_ff <= set_row;
      end
   end

   assign fwd_onehot = GRID_HEIGHT'(1) << s1_fwd_row_ff;
   assign col_a_eff  = s1_fwd_ff.clear ? '0
                     : ((rd_valid_a ? rd_word_a : '0) | (s1_fwd_ff.hit_a ? fwd_onehot : '0));
   assign col_b_eff  = (s1_fwd_ff.clear || s1_edge_ff) ? '0
                     : ((rd_valid_b ? rd_word_b : '0) | (s1_fwd_ff.hit_b ? fwd_onehot : '0));
   assign age_eff    = s1_fwd_ff.hit_age ? '0 : rd_age;

   assign hold0_in = (s1_y_ff == '0) ? ((s1_x_ff == '0) ? '0 : hold1_ff) : hold0_ff;
   assign hold1_in = (s1_y_ff == '0) ? col_a_eff : hold1_ff;

   lcge_rule #(
      .GRID_HEIGHT (GRID_HEIGHT),
      .AGE_BITS    (AGE_BITS)
   ) u_rule (
      .hold0   (hold0_in),
      .hold1   (hold1_in),
      .ahead   (col_b_eff),
      .row     (s1_y_ff),
      .age_old (age_eff),
      .thr     (thr_ff),
      .flags   (flags),
      .age_new (age_new)
   );

   always_comb begin
      store_ctl.rd_en = req_fire && (req_cmd == CMD_EVAL);
      store_ctl.wr_en = 1'b0;
      store_ctl.clear = 1'b0;
      wr_col   = s1_x_ff;
      wr_row   = s1_y_ff;
      wr_alive = flags.alive_next;
      wr_age   = age_new;
      if (s1_move) begin
         unique case (s1_cmd_ff)
            CMD_CLEAR: begin
               store_ctl.clear = 1'b1;
            end
            CMD_SET: begin
               store_ctl.wr_en = set_ok;
               wr_col   = set_col;
               wr_row   = set_row;
               wr_alive = 1'b1;
               wr_age   = '0;
            end
            CMD_EVAL: begin
               store_ctl.wr_en = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   lcge_store #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .AGE_BITS    (AGE_BITS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (store_ctl),
      .rd_col_a   (scan_x_ff),
      .rd_col_b   (rd_col_b),
      .rd_row     (scan_y_ff),
      .wr_col     (wr_col),
      .wr_row     (wr_row),
      .wr_alive   (wr_alive),
      .wr_age     (wr_age),
      .rd_word_a  (rd_word_a),
      .rd_word_b  (rd_word_b),
      .rd_valid_a (rd_valid_a),
      .rd_valid_b (rd_valid_b),
      .rd_age     (rd_age)
   );

   always_ff @(posedge clock) begin
      if (s1_move && s1_is_eval) begin
         hold0_ff <= hold0_in;
         hold1_ff <= hold1_in;
      end
   end

   assign s1_last = (s1_x_ff == COL_LAST) && (s1_y_ff == ROW_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_move && s1_is_eval) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_is_eval) begin
         rsp_word_ff.aged       <= flags.aged;
         rsp_word_ff.died       <= flags.died;
         rsp_word_ff.born       <= flags.born;
         rsp_word_ff.alive_next <= flags.alive_next;
         rsp_word_ff.pos_y      <= COORD_W'(s1_y_ff);
         rsp_word_ff.pos_x      <= COORD_W'(s1_x_ff);
         rsp_last_ff            <= s1_last;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign rsp_flags_ok  = !(rsp_word_ff.born && rsp_word_ff.died)
                        && (!rsp_word_ff.aged || rsp_word_ff.alive_next)
                        && (!rsp_word_ff.born || rsp_word_ff.alive_next);
   assign rsp_at_corner = (rsp_word_ff.pos_x == COORD_W'(GRID_WIDTH - 1))
                        && (rsp_word_ff.pos_y == COORD_W'(GRID_HEIGHT - 1));

   `LCGE_ASSERT_NEXT(a_eval_gives_rsp, clock, reset, s1_move && s1_is_eval, rsp_vld_ff)
   `LCGE_ASSERT_IMP(a_flags_agree, clock, reset, rsp_vld_ff, rsp_flags_ok)
   `LCGE_ASSERT_IMP(a_last_at_corner, clock, reset, rsp_vld_ff && rsp_last_ff, rsp_at_corner)
   `LCGE_ASSERT_IMP(a_stall_only_on_rsp, clock, reset, !req_tready, s1_vld_ff && s1_is_eval && rsp_vld_ff && !rsp_tready)

endmodule

/* sim/life_scan_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_scan_checker
// watches the request, response and csr channels of the life cell engine,
// keeps its own copy of the grid, ages, held columns and scan position, and
// compares every response word with the predicted cell in order
// ----------------------------------------------------------------------------
module life_scan_checker import lcge_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // cell_x, cell_y, zero fill
   input  logic [CMD_W-1:0]      req_tuser,  // command
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // pos_x, pos_y, alive_next, born, died, aged
   input  logic                  rsp_tlast,  // gen_last
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [THR_W-1:0]      csr_wdata,  // age_threshold
   output int                    mismatch_count,
   output int                    cells_outstanding
);

   localparam int SIDE        = 64;
   localparam int MAX_REPORTS = 10;
   localparam logic [THR_W-1:0] AGE_CAP = '1;

   typedef struct {
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic               alive_next;
      logic               born;
      logic               died;
      logic               aged;
      logic               gen_last;
   } cell_result_type;

   logic [SIDE-1:0]    grid_alive [SIDE];  // one column per x, bit y
   logic [THR_W-1:0]   grid_age [SIDE][SIDE];
   logic [SIDE-1:0]    prev_column;
   logic [SIDE-1:0]    this_column;
   int                 scan_col;
   int                 scan_row;
   logic [THR_W-1:0]   age_threshold;
   cell_result_type    expected_cells [$];

   task automatic clear_grid();
      foreach (grid_alive[i]) grid_alive[i] = '0;
      foreach (grid_age[i, j]) grid_age[i][j] = '0;
      prev_column = '0;
      this_column = '0;
      scan_col    = 0;
      scan_row    = 0;
   endtask

   function automatic int col_bit(logic [SIDE-1:0] col, int row);
      return (row >= 0 && row < SIDE) ? int'(col[row]) : 0;
   endfunction

   task automatic evaluate_cell();
      int               x;
      int               y;
      int               count;
      int               next_age;
      logic [SIDE-1:0]  ahead_col;
      logic             was_alive;
      logic             now_alive;
      logic [THR_W-1:0] cap;
      cell_result_type  want;
      x = scan_col;
      y = scan_row;
      if (y == 0) begin
         prev_column = (x == 0) ? '0 : this_column;
         this_column = grid_alive[x];
      end
      ahead_col = (x + 1 < SIDE) ? grid_alive[x + 1] : '0;
      count = 0;
      for (int d = -1; d <= 1; d++) begin
         count += col_bit(prev_column, y + d) + col_bit(ahead_col, y + d);
         if (d != 0) count += col_bit(this_column, y + d);
      end
      was_alive = this_column[y];
      if (was_alive) now_alive = (count == KEEP_COUNT || count == BIRTH_COUNT);
      else now_alive = (count == BIRTH_COUNT);
      cap = (age_threshold < AGE_CAP) ? age_threshold : AGE_CAP;
      if (now_alive && was_alive) begin
         next_age = int'(grid_age[x][y]) + 1;
         if (next_age > cap) next_age = cap;
      end else begin
         next_age = 0;
      end
      grid_alive[x][y] = now_alive;
      grid_age[x][y]   = next_age[THR_W-1:0];

      want.pos_x      = x[COORD_W-1:0];
      want.pos_y      = y[COORD_W-1:0];
      want.alive_next = now_alive;
      want.born       = now_alive && !was_alive;
      want.died       = !now_alive && was_alive;
      want.aged       = now_alive && (next_age >= age_threshold);
      want.gen_last   = (x == SIDE - 1 && y == SIDE - 1);
      expected_cells.push_back(want);

      if (y + 1 < SIDE) begin
         scan_row = y + 1;
      end else begin
         scan_row = 0;
         scan_col = (x + 1 < SIDE) ? x + 1 : 0;
      end
   endtask

   task automatic check_cell();
      rsp_word_type    got;
      cell_result_type want;
      got = rsp_tdata;
      if (expected_cells.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("unexpected word: x=%0d y=%0d alive=%b born=%b died=%b aged=%b last=%b",
                     got.pos_x, got.pos_y, got.alive_next, got.born, got.died, got.aged, rsp_tlast);
         return;
      end
      want = expected_cells.pop_front();
      if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y
            || got.alive_next !== want.alive_next || got.born !== want.born
            || got.died !== want.died || got.aged !== want.aged
            || rsp_tlast !== want.gen_last) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("cell mismatch, expected x=%0d y=%0d alive=%b born=%b died=%b aged=%b last=%b",
                     want.pos_x, want.pos_y, want.alive_next, want.born, want.died,
                     want.aged, want.gen_last);
            $display("                    got x=%0d y=%0d alive=%b born=%b died=%b aged=%b last=%b",
                     got.pos_x, got.pos_y, got.alive_next, got.born, got.died, got.aged,
                     rsp_tlast);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_grid();
         age_threshold  = THR_RESET;
         mismatch_count = 0;
         expected_cells.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_cell();
         if (csr_valid && csr_ready) age_threshold = csr_wdata;
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               CMD_CLEAR: clear_grid();
               CMD_SET: begin
                  grid_alive[req_tdata[COORD_W-1:0]][req_tdata[2*COORD_W-1:COORD_W]] = 1'b1;
                  grid_age[req_tdata[COORD_W-1:0]][req_tdata[2*COORD_W-1:COORD_W]]   = '0;
               end
               CMD_EVAL: evaluate_cell();
               default: ;
            endcase
         end
      end
      cells_outstanding = expected_cells.size();
   end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives clear, set and evaluate words into the life cell engine: a short
// directed opening, then random soups run through the first columns of the
// scan under several age thresholds, with random stalls on both channels
// ----------------------------------------------------------------------------
module testbench;
   import lcge_pkg::*;

   localparam int SIDE         = 64;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int SOUP_SPAN    = 8;
   localparam int SCAN_COLS    = 3;
   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;  // unused command code

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [THR_W-1:0]      csr_wdata;

   int                    mismatch_count;
   int                    cells_outstanding;
   bit                    calm = 1'b0;
   int                    idle_cycles = 0;
   int                    words_sent = 0;
   int                    results_taken = 0;
   int                    aged_seen = 0;
   rsp_word_type          rsp_word;

   assign rsp_word = rsp_tdata;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   life_cell_generation_engine_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   life_scan_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tlast         (rsp_tlast),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .cells_outstanding (cells_outstanding)
   );

   // watchdog and run statistics
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
            || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
         if (req_tvalid && req_tready) words_sent <= words_sent + 1;
         if (rsp_tvalid && rsp_tready) begin
            results_taken <= results_taken + 1;
            if (rsp_word.aged) aged_seen <= aged_seen + 1;
         end
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side back-pressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(15) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_word(logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] cx,
                            logic [COORD_W-1:0] cy);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_DATA_W - 2 * COORD_W){1'b0}}, cy, cx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (!calm && $urandom_range(9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (cells_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_threshold(logic [THR_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int pick_origin();
      case ($urandom_range(2))
         0: return 0;
         1: return SIDE - SOUP_SPAN;
         default: return $urandom_range(SIDE - SOUP_SPAN);
      endcase
   endfunction

   // random soups near the start of the scan, top and bottom edges included
   task automatic seed_soup();
      int ox;
      int oy;
      for (int w = 0; w < 2; w++) begin
         ox = $urandom_range(3);
         oy = pick_origin();
         for (int i = 0; i < SOUP_SPAN; i++)
            for (int j = 0; j < SOUP_SPAN; j++)
               if ($urandom_range(9) < 4)
                  send_word(CMD_SET, COORD_W'(ox + i), COORD_W'(oy + j));
      end
   endtask

   // evaluate words with sets and unused commands mixed into the scan
   task automatic run_scan(int cells);
      int left;
      left = cells;
      while (left > 0) begin
         case ($urandom_range(127))
            0, 1, 2: send_word(CMD_SET, COORD_W'($urandom_range(SIDE - 1)),
                               COORD_W'($urandom_range(SIDE - 1)));
            3: send_word(CMD_NONE, COORD_W'($urandom_range(SIDE - 1)),
                         COORD_W'($urandom_range(SIDE - 1)));
            default: begin
               send_word(CMD_EVAL, COORD_W'($urandom_range(SIDE - 1)),
                         COORD_W'($urandom_range(SIDE - 1)));
               left--;
            end
         endcase
      end
   endtask

   initial begin : stimulus
      int  thr_pick;
      bit  fresh;
      int  last_thr;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_CLEAR;
      csr_valid  = 1'b0;
      csr_wdata  = '0;
      last_thr   = 0;
      reset      = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening at the reset threshold
      send_word(CMD_EVAL, 6'd63, 6'd63);
      send_word(CMD_SET, 6'd0, 6'd0);
      send_word(CMD_SET, 6'd0, 6'd1);
      send_word(CMD_SET, 6'd1, 6'd0);
      send_word(CMD_SET, 6'd63, 6'd63);
      send_word(CMD_SET, 6'd63, 6'd62);
      send_word(CMD_SET, 6'd62, 6'd63);
      send_word(CMD_SET, 6'd63, 6'd0);
      send_word(CMD_SET, 6'd0, 6'd63);
      send_word(CMD_NONE, 6'd63, 6'd63);
      send_word(CMD_EVAL, 6'd0, 6'd0);
      send_word(CMD_EVAL, 6'd63, 6'd0);
      send_word(CMD_SET, 6'd0, 6'd3);   // column already held
      send_word(CMD_SET, 6'd1, 6'd4);   // column ahead of the scan
      send_word(CMD_EVAL, 6'd0, 6'd63);
      send_word(CMD_EVAL, 6'd21, 6'd42);
      send_word(CMD_EVAL, 6'd42, 6'd21);
      send_word(CMD_CLEAR, 6'd63, 6'd63);
      send_word(CMD_EVAL, 6'd0, 6'd0);
      send_word(CMD_NONE, 6'd0, 6'd0);

      // first scan columns under several thresholds
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin thr_pick = 1;  fresh = 1'b1; end
            1: begin thr_pick = 0;  fresh = 1'b0; end
            2: begin thr_pick = 2;  fresh = 1'b1; end
            3: begin thr_pick = 63; fresh = 1'b0; end
            default: begin thr_pick = $urandom_range(3, 62); fresh = 1'b1; end
         endcase
         set_threshold(THR_W'(thr_pick));
         last_thr = thr_pick;
         calm = (p == 4);
         if (fresh) begin
            send_word(CMD_CLEAR, COORD_W'($urandom_range(SIDE - 1)),
                      COORD_W'($urandom_range(SIDE - 1)));
            seed_soup();
         end
         run_scan(SCAN_COLS * SIDE);
      end

      drain();
      $display("run covered %0d request words and %0d evaluated cells",
               words_sent, results_taken);
      $display("thresholds 10 (reset), 1, 0, 2, 63 and %0d; %0d cells came back aged",
               last_thr, aged_seen);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
